/* rtl/fqs_pkg.sv */
// Package for the FIFO queue with search: depth, widths, operation and
// status codes, result record and pointer helpers.
// No dependencies.
package fqs_pkg;

    // Queue geometry
    localparam int DEPTH  = 16;
    localparam int PTR_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    // Fixed field widths
    localparam int DATA_W = 32;
    localparam int FUNC_W = 2;
    localparam int IDX_W  = 5;
    localparam int OCC_W  = 5;
    localparam int STAT_W = 2;

    // Operation codes
    typedef enum logic [FUNC_W-1:0] {
        FN_PUSH   = 2'd0,
        FN_POP    = 2'd1,
        FN_SEARCH = 2'd2,
        FN_NOP    = 2'd3
    } t_func;

    // Status codes
    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    // One finished transaction
    typedef struct packed {
        logic [DATA_W-1:0] result_value;
        logic [IDX_W-1:0]  match_index;
        t_status           status;
        logic              is_empty;
        logic [DATA_W-1:0] front_value;
        logic [OCC_W-1:0]  occupancy;
    } t_result;

    // Advance a pointer by one slot, wrapping at the queue depth
    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] q;
        q = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
        return q;
    endfunction

endpackage

/* rtl/fqs_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module fqs_ram #(
    parameter int WIDTH = 32,
    parameter int WORDS = 16,
    parameter int AW    = 4
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [WORDS];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port with registered read data
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/fqs_ctrl.sv */
// Queue sequencer: head/tail/count, cached front word, pop refill and
// one-entry-per-cycle search over the entry RAM.
// Depends on fqs_pkg.
module fqs_ctrl import fqs_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [FUNC_W-1:0] i_func,
    input  logic [DATA_W-1:0] i_value,
    output logic              o_busy,
    output logic              o_wr_en,
    output logic [PTR_W-1:0]  o_wr_addr,
    output logic [DATA_W-1:0] o_wr_data,
    output logic [PTR_W-1:0]  o_rd_addr,
    input  logic [DATA_W-1:0] i_rd_data,
    output logic              o_res_valid,
    output t_result           o_res
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_POP    = 3'b010,
        S_SEARCH = 3'b100
    } t_state;

    t_state            r_state, n_state;
    logic [PTR_W-1:0]  r_head, n_head;
    logic [PTR_W-1:0]  r_tail, n_tail;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [DATA_W-1:0] r_front, n_front;
    logic [DATA_W-1:0] r_key, n_key;
    logic [DATA_W-1:0] r_pop_val, n_pop_val;
    logic [PTR_W-1:0]  r_ptr, n_ptr;
    logic [PTR_W-1:0]  r_idx, n_idx;
    logic              w_accept;
    logic [DATA_W-1:0] w_front_out;
    logic [CNT_W:0]    w_sum;

    assign w_accept    = i_start && (r_state == S_IDLE);
    assign o_busy      = (r_state != S_IDLE);
    assign w_front_out = (r_count == '0) ? '1 : r_front;

    // Next state, pointers and the result of the finishing cycle
    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_front     = r_front;
        n_key       = r_key;
        n_pop_val   = r_pop_val;
        n_ptr       = r_ptr;
        n_idx       = r_idx;
        o_wr_en     = 1'b0;
        o_wr_addr   = r_tail;
        o_wr_data   = i_value;
        o_rd_addr   = next_slot(r_ptr);
        o_res_valid = 1'b0;
        o_res.result_value = '0;
        o_res.match_index  = '0;
        o_res.status       = ST_OK;
        o_res.is_empty     = (r_count == '0);
        o_res.front_value  = w_front_out;
        o_res.occupancy    = OCC_W'(r_count);

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (t_func'(i_func))
                        FN_PUSH: begin
                            o_res_valid = 1'b1;
                            if (r_count == CNT_W'(DEPTH)) begin
                                o_res.status = ST_FULL;
                            end else begin
                                // Append at tail; an empty queue takes it as front
                                o_wr_en = 1'b1;
                                n_tail  = next_slot(r_tail);
                                n_count = r_count + CNT_W'(1);
                                if (r_count == '0) begin
                                    n_front = i_value;
                                end
                                o_res.is_empty    = 1'b0;
                                o_res.front_value = (r_count == '0) ? i_value : r_front;
                                o_res.occupancy   = OCC_W'(r_count + CNT_W'(1));
                            end
                        end
                        FN_POP: begin
                            if (r_count == '0) begin
                                o_res_valid        = 1'b1;
                                o_res.result_value = '1;
                                o_res.status       = ST_EMPTY;
                            end else begin
                                n_head  = next_slot(r_head);
                                n_count = r_count - CNT_W'(1);
                                if (r_count == CNT_W'(1)) begin
                                    // Last entry leaves: no refill needed
                                    o_res_valid        = 1'b1;
                                    o_res.result_value = r_front;
                                    o_res.is_empty     = 1'b1;
                                    o_res.front_value  = '1;
                                    o_res.occupancy    = '0;
                                end else begin
                                    // Fetch the new front word
                                    o_rd_addr = next_slot(r_head);
                                    n_pop_val = r_front;
                                    n_state   = S_POP;
                                end
                            end
                        end
                        FN_SEARCH: begin
                            if (r_count == '0) begin
                                o_res_valid       = 1'b1;
                                o_res.match_index = '1;
                                o_res.status      = ST_NOT_FOUND;
                            end else begin
                                // Start the scan at the front entry
                                o_rd_addr = r_head;
                                n_ptr     = r_head;
                                n_idx     = '0;
                                n_key     = i_value;
                                n_state   = S_SEARCH;
                            end
                        end
                        default: begin
                            o_res_valid = 1'b1;
                        end
                    endcase
                end
            end
            S_POP: begin
                n_front            = i_rd_data;
                o_res_valid        = 1'b1;
                o_res.result_value = r_pop_val;
                o_res.front_value  = i_rd_data;
                n_state            = S_IDLE;
            end
            S_SEARCH: begin
                if (i_rd_data == r_key) begin
                    o_res_valid       = 1'b1;
                    o_res.match_index = IDX_W'(r_idx);
                    n_state           = S_IDLE;
                end else if (CNT_W'(r_idx) + CNT_W'(1) == r_count) begin
                    o_res_valid       = 1'b1;
                    o_res.match_index = '1;
                    o_res.status      = ST_NOT_FOUND;
                    n_state           = S_IDLE;
                end else begin
                    // Advance to the next entry; its read is issued now
                    n_ptr = next_slot(r_ptr);
                    n_idx = r_idx + PTR_W'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    // Payload and scan registers
    always_ff @(posedge i_clk) begin
        r_front   <= n_front;
        r_key     <= n_key;
        r_pop_val <= n_pop_val;
        r_ptr     <= n_ptr;
        r_idx     <= n_idx;
    end

    assign w_sum = (CNT_W+1)'(r_head) + (CNT_W+1)'(r_count);

    // Tail always sits count slots past head
    a_ptr_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tail == PTR_W'((w_sum >= (CNT_W+1)'(DEPTH)) ? w_sum - (CNT_W+1)'(DEPTH) : w_sum))
        else $error("tail does not match head plus count");

    // Occupancy stays within the store
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count beyond depth");

    // A scan never runs past the last held entry
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEARCH) |-> (CNT_W'(r_idx) < r_count))
        else $error("search index past occupancy");

    // A result is only produced while working or on an accepted transaction
    a_res_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (w_accept || (r_state != S_IDLE)))
        else $error("result without a transaction");

    // A successful push grows the queue by one
    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (t_func'(i_func) == FN_PUSH) && (r_count != CNT_W'(DEPTH)))
        |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("push did not advance count");

endmodule

/* rtl/fifo_queue_with_search.sv */
// FIFO queue with search, top level: sequencer, entry RAM and result register.
// Depends on fqs_pkg, fqs_ram and fqs_ctrl.
//
// A transaction is taken when start is high and busy is low; its result
// appears on the o_ ports, marked by o_valid, for one cycle only and cannot
// be stalled. Push and the unused code finish in the accepting cycle, as
// does any pop that empties the queue or finds it empty; another pop also
// waits in S_POP for the new front word to come back through the RAM's
// registered read port. A search scans one entry per cycle from the front,
// in S_SEARCH, until a match or until every held entry has been compared.
// The result is registered: o_valid rises in the cycle after the last
// working cycle; busy is already low then, so the next transaction can be
// taken while that result is shown.
module fifo_queue_with_search import fqs_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [FUNC_W-1:0] i_func,
    input  logic [DATA_W-1:0] i_value,
    output logic              o_valid,
    output logic [DATA_W-1:0] o_result_value,
    output logic [IDX_W-1:0]  o_match_index,
    output logic [STAT_W-1:0] o_status,
    output logic              o_is_empty,
    output logic [DATA_W-1:0] o_front_value,
    output logic [OCC_W-1:0]  o_occupancy
);

    logic              w_wr_en;
    logic [PTR_W-1:0]  w_wr_addr;
    logic [DATA_W-1:0] w_wr_data;
    logic [PTR_W-1:0]  w_rd_addr;
    logic [DATA_W-1:0] w_rd_data;
    logic              w_res_valid;
    t_result           w_res;
    logic              r_valid;
    t_result           r_res;

    fqs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_func      (i_func),
        .i_value     (i_value),
        .o_busy      (busy),
        .o_wr_en     (w_wr_en),
        .o_wr_addr   (w_wr_addr),
        .o_wr_data   (w_wr_data),
        .o_rd_addr   (w_rd_addr),
        .i_rd_data   (w_rd_data),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    fqs_ram #(
        .WIDTH (DATA_W),
        .WORDS (DEPTH),
        .AW    (PTR_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // Hold the result strobe for one cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_res_valid;
        end
    end

    // Capture the result payload
    always_ff @(posedge i_clk) begin
        if (w_res_valid) begin
            r_res <= w_res;
        end
    end

    assign o_valid        = r_valid;
    assign o_result_value = r_res.result_value;
    assign o_match_index  = r_res.match_index;
    assign o_status       = r_res.status;
    assign o_is_empty     = r_res.is_empty;
    assign o_front_value  = r_res.front_value;
    assign o_occupancy    = r_res.occupancy;

endmodule
